[rtl/bisc_pkg.sv]
// Package for the bounded integer set store: field widths, mode and status codes,
// and the control bundle broadcast along the row of entry cells.
// No dependencies.
`default_nettype none

package bisc_pkg;

   localparam int VALUE_W    = 32;
   localparam int MODE_W     = 2;
   localparam int POS_W      = 7;
   localparam int STATUS_W   = 4;
   localparam int COUNT_W    = 8;
   localparam int CAPACITY_W = 8;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 8'd100;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_ADDED    = 4'd0;
   localparam logic [STATUS_W-1:0] STAT_DUP      = 4'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 4'd2;
   localparam logic [STATUS_W-1:0] STAT_REMOVED  = 4'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 4'd4;
   localparam logic [STATUS_W-1:0] STAT_PRESENT  = 4'd5;
   localparam logic [STATUS_W-1:0] STAT_ABSENT   = 4'd6;
   localparam logic [STATUS_W-1:0] STAT_READOK   = 4'd7;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 4'd8;

   // Control broadcast to every cell in the row.
   typedef struct packed {
      logic               cmp_en;
      logic               add_en;
      logic               del_en;
      logic [VALUE_W-1:0] cmp_value;
      logic [VALUE_W-1:0] add_value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      IDLE = 2'b01,
      EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

[rtl/bisc_cell.sv]
// One entry cell of the set store row: holds one value, compares it against the
// broadcast key, and takes its upper neighbor's value when a delete closes a gap.
// Depends on bisc_pkg.
`default_nettype none

module bisc_cell
   import bisc_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 7,
   parameter int CNT_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_ctl_type       ctl,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic [IDX_W-1:0]   del_idx,
   input  wire logic [IDX_W-1:0]   rd_idx,
   input  wire logic [VALUE_W-1:0] next_entry,
   output logic      [VALUE_W-1:0] entry,
   output logic                    hit,
   output logic      [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               hit_ff;
   logic               hit_in;
   logic               occupied;

   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      hit_in   = hit_ff;
      entry_in = entry_ff;
      if (ctl.cmp_en) begin
         hit_in = occupied && (entry_ff == ctl.cmp_value);
      end
      if (ctl.add_en && (CNT_W'(INDEX) == count)) begin
         entry_in = ctl.add_value;
      end
      // Every cell at or above the removed one takes its neighbor's value.
      if (ctl.del_en && (IDX_W'(INDEX) >= del_idx)) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry   = entry_ff;
   assign hit     = hit_ff;
   assign rd_data = (IDX_W'(INDEX) == rd_idx) ? entry_ff : '0;

endmodule

`default_nettype wire

[rtl/bisc_collect.sv]
// Gathers the per-cell outputs of the set store row: encodes the single hit into
// an index and merges the gated read words of all cells.
// Depends on bisc_pkg.
`default_nettype none

module bisc_collect
   import bisc_pkg::*;
#(
   parameter int N     = 128,
   parameter int IDX_W = 7
) (
   input  wire logic [N-1:0]              hits,
   input  wire logic [N-1:0][VALUE_W-1:0] rd_words,
   output logic                           any_hit,
   output logic      [IDX_W-1:0]          hit_idx,
   output logic      [VALUE_W-1:0]        rd_word
);

   // Entries are distinct, so at most one hit is set and an OR encode is exact.
   always_comb begin
      hit_idx = '0;
      rd_word = '0;
      for (int i = 0; i < N; i++) begin
         if (hits[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
         rd_word = rd_word | rd_words[i];
      end
   end

   assign any_hit = |hits;

endmodule

`default_nettype wire

[rtl/bounded_integer_set_store.sv]
// Bounded integer set store: an ordered, duplicate-free list of signed 32-bit
// values held in a row of entry cells, one value per cell.
// Request channel (req_*): mode, value and position; one transaction per item.
// Response channel (rsp_*): status, count after the operation, and the element
// for reads. Every request gives exactly one response, in order.
// Config channel (csr_*): writes the capacity register; always ready. Write it
// only while no request is in flight.
// Each request has two steps: the accepting edge broadcasts the value to all
// cells for compare, and a later edge, once the response register is free, commits the add, the one-step shift of a
// delete, or the read, and loads the response register. A new request is not
// accepted until the previous one has made this compare-then-commit pair.
// The response register decouples the sides: a new request is accepted while a
// response waits; if the receiver stalls, the commit of the next request waits
// until the response register is free.
// Reset (synchronous, active high) empties the store and sets capacity to 100.
// Cell contents are not cleared; only cells below the count are ever used.
`default_nettype none

module bounded_integer_set_store
   import bisc_pkg::*;
#(
   parameter int MAX_ENTRIES = 128
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CAPACITY_W-1:0]      csr_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [MODE_W-1:0]          req_mode,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]           req_position,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [COUNT_W-1:0]              rsp_count,
   output logic signed [VALUE_W-1:0]       rsp_element
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int POS_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CAP_CMP_W = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;

   state_type               state_ff, state_in;
   logic [CAPACITY_W-1:0]   capacity_ff, capacity_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MODE_W-1:0]       mode_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [POS_W-1:0]        position_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]      rsp_element_ff, rsp_element_in;

   cell_ctl_type                      ctl;
   logic [MAX_ENTRIES-1:0]            hits;
   logic [MAX_ENTRIES-1:0][VALUE_W-1:0] entries;
   logic [MAX_ENTRIES-1:0][VALUE_W-1:0] rd_words;
   logic                              any_hit;
   logic [IDX_W-1:0]                  hit_idx;
   logic [VALUE_W-1:0]                rd_word;
   logic [IDX_W-1:0]                  rd_idx;
   logic [POS_CMP_W-1:0]              pos_ext, cnt_pos_ext, pos_clamped;
   logic [CAP_CMP_W-1:0]              cap_ext, cnt_cap_ext;
   logic                              full;
   logic                              commit;
   logic                              req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == IDLE);
   assign req_fire  = req_valid && req_ready;
   assign commit    = (state_ff == EXEC) && (!rsp_valid_ff || rsp_ready);

   // A capacity of zero acts as one; anything above the row length acts as the row length.
   assign cap_ext     = (capacity_ff == '0) ? CAP_CMP_W'(1) : CAP_CMP_W'(capacity_ff);
   assign cnt_cap_ext = CAP_CMP_W'(count_ff);
   assign full        = (count_ff >= CNT_W'(MAX_ENTRIES)) || (cnt_cap_ext >= cap_ext);

   assign pos_ext     = POS_CMP_W'(position_ff);
   assign cnt_pos_ext = POS_CMP_W'(count_ff);
   assign pos_clamped = (pos_ext >= cnt_pos_ext) ? cnt_pos_ext - POS_CMP_W'(1) : pos_ext;
   assign rd_idx      = pos_clamped[IDX_W-1:0];

   assign ctl.cmp_en    = req_fire;
   assign ctl.cmp_value = req_value;
   assign ctl.add_value = value_ff;
   assign ctl.add_en    = commit && (mode_ff == MODE_ADD) && !any_hit && !full;
   assign ctl.del_en    = commit && (mode_ff == MODE_DELETE) && any_hit;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [VALUE_W-1:0] next_entry;
      if (i == MAX_ENTRIES - 1) begin : g_top
         assign next_entry = entries[i];
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end
      bisc_cell #(
         .INDEX (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .count      (count_ff),
         .del_idx    (hit_idx),
         .rd_idx     (rd_idx),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .hit        (hits[i]),
         .rd_data    (rd_words[i])
      );
   end

   bisc_collect #(
      .N     (MAX_ENTRIES),
      .IDX_W (IDX_W)
   ) u_collect (
      .hits     (hits),
      .rd_words (rd_words),
      .any_hit  (any_hit),
      .hit_idx  (hit_idx),
      .rd_word  (rd_word)
   );

   always_comb begin
      state_in       = state_ff;
      capacity_in    = capacity_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;

      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (commit) begin
               state_in       = IDLE;
               rsp_valid_in   = 1'b1;
               rsp_element_in = '0;
               unique case (mode_ff)
                  MODE_ADD: begin
                     if (any_hit) begin
                        rsp_status_in = STAT_DUP;
                     end else if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_ADDED;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (any_hit) begin
                        rsp_status_in = STAT_REMOVED;
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = STAT_NOTFOUND;
                     end
                  end
                  MODE_QUERY: begin
                     rsp_status_in = any_hit ? STAT_PRESENT : STAT_ABSENT;
                  end
                  MODE_READ: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_status_in  = STAT_READOK;
                        rsp_element_in = rd_word;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_EMPTY;
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_mode;
         value_ff    <= req_value;
         position_ff <= req_position;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      if (reset) begin
         state_ff     <= IDLE;
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_element = rsp_element_ff;

   // The row never holds more entries than it has cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count exceeds row length");

   // Stored entries are distinct, so a compare never hits two cells.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == EXEC) |-> $onehot0(hits))
      else $error("more than one cell matched the key");

   // The count moves only on a commit edge.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(commit))
      else $error("entry count changed outside a commit");

   // A new response appears only from a commit.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response raised without a commit");

endmodule

`default_nettype wire

[tb/bisc_set_checker.sv]
`timescale 1ns / 100ps
// Response checker for the bounded integer set store: keeps its own copy of the set and
// the capacity register, predicts each response and compares it with what the block returns.
// Depends on bisc_pkg for field widths, mode codes and status codes.
module bisc_set_checker
   import bisc_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CAPACITY_W-1:0] csr_data,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [VALUE_W-1:0]    req_value,
   input  wire logic [POS_W-1:0]      req_position,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [STATUS_W-1:0]   rsp_status,
   input  wire logic [COUNT_W-1:0]    rsp_count,
   input  wire logic [VALUE_W-1:0]    rsp_element,
   output int                         fail_count,
   output int                         outstanding
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [VALUE_W-1:0]  element;
   } set_rsp_type;

   logic [VALUE_W-1:0]    set_entries [DEPTH];
   int unsigned           set_size;
   logic [CAPACITY_W-1:0] capacity_reg;
   set_rsp_type           awaited_rsps [$];
   int                    errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // A capacity of zero behaves as one, anything above the depth as the depth.
   function automatic int unsigned usable_capacity();
      if (capacity_reg == '0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return capacity_reg;
   endfunction

   // Index of the value, or the current size when it is not stored.
   function automatic int unsigned locate(logic [VALUE_W-1:0] v);
      for (int i = 0; i < set_size; i++) begin
         if (set_entries[i] == v) return i;
      end
      return set_size;
   endfunction

   task automatic apply_set_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos, output set_rsp_type r);
      int unsigned idx;
      int unsigned slot;
      r = '0;
      idx = locate(value);
      case (mode)
         MODE_ADD: begin
            // A duplicate is reported ahead of a full store.
            if (idx < set_size) begin
               r.status = STAT_DUP;
            end else if (set_size >= usable_capacity()) begin
               r.status = STAT_FULL;
            end else begin
               set_entries[set_size] = value;
               set_size++;
               r.status = STAT_ADDED;
            end
         end
         MODE_DELETE: begin
            if (idx < set_size) begin
               for (int j = idx; j + 1 < set_size; j++) set_entries[j] = set_entries[j + 1];
               set_size--;
               r.status = STAT_REMOVED;
            end else begin
               r.status = STAT_NOTFOUND;
            end
         end
         MODE_QUERY: begin
            r.status = (idx < set_size) ? STAT_PRESENT : STAT_ABSENT;
         end
         MODE_READ: begin
            if (set_size == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               slot = pos;
               if (slot >= set_size) slot = set_size - 1;
               r.element = set_entries[slot];
               r.status  = STAT_READOK;
            end
         end
      endcase
      r.count = COUNT_W'(set_size);
   endtask

   always @(posedge clock) begin
      set_rsp_type got;
      set_rsp_type want;
      set_rsp_type predicted;
      if (reset) begin
         set_size     = 0;
         capacity_reg = CAPACITY_RESET;
         awaited_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status  = rsp_status;
            got.count   = rsp_count;
            got.element = rsp_element;
            if (awaited_rsps.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response with no request waiting: status %0d count %0d",
                           $time, got.status, got.count);
            end else begin
               want = awaited_rsps.pop_front();
               if (got.status !== want.status || got.count !== want.count ||
                   got.element !== want.element) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: response mismatch: status exp %0d got %0d, count exp %0d got %0d, element exp %0d got %0d",
                              $time, want.status, got.status, want.count, got.count,
                              $signed(want.element), $signed(got.element));
               end
            end
         end
         if (csr_valid && csr_ready) capacity_reg = csr_data;
         if (req_valid && req_ready) begin
            apply_set_op(req_mode, req_value, req_position, predicted);
            awaited_rsps.push_back(predicted);
         end
      end
      fail_count  <= errors;
      outstanding <= awaited_rsps.size();
   end

endmodule

[tb/bounded_integer_set_store_tb.sv]
`timescale 1ns / 100ps
// Top of the bounded integer set store testbench: clock, reset, request and capacity
// stimulus, response back-pressure and the verdict.
// Depends on bisc_pkg, bounded_integer_set_store and bisc_set_checker.
module bounded_integer_set_store_tb;
   import bisc_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int DEPTH        = 128;
   localparam int MAX_GAP      = 18;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CAPACITY_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = MODE_ADD;
   logic [VALUE_W-1:0]    req_value = '0;
   logic [POS_W-1:0]      req_position = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_count;
   logic signed [VALUE_W-1:0] rsp_element;

   int                    fail_count;
   int                    outstanding;
   int                    idle_cycles = 0;
   bit                    quiet = 1'b0;
   logic [VALUE_W-1:0]    pool [$];

   always #(CLK_PERIOD / 2) clock = ~clock;

   bounded_integer_set_store #(.MAX_ENTRIES(DEPTH)) DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_element  (rsp_element)
   );

   bisc_set_checker #(.DEPTH(DEPTH)) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_element  (rsp_element),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // Counts cycles in which no transaction completes on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("bounded_integer_set_store regression: fail");
      $finish;
   end

   function automatic int pick_gap();
      return quiet ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Response side: waits a random number of cycles, then accepts one transaction.
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // Called and returns at a falling edge; valid stays high when the next request
   // follows without a gap.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode     = mode;
      req_value    = value;
      req_position = pos;
      req_valid    = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Holds off new requests until every response is back and the block is idle.
   task automatic settle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAPACITY_W-1:0] cap);
      csr_data  = cap;
      csr_valid = 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic build_pool(input int n);
      int r;
      pool.delete();
      repeat (n) begin
         r = $urandom_range(0, 9);
         case (r)
            0:       pool.push_back(32'h8000_0000);
            1:       pool.push_back(32'h7FFF_FFFF);
            2, 3, 4: pool.push_back(VALUE_W'($signed($urandom_range(0, 40)) - 20));
            default: pool.push_back($urandom());
         endcase
      end
   endtask

   task automatic random_request(input int add_pct, input int del_pct);
      int                 roll;
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) mode = MODE_ADD;
      else if (roll < add_pct + del_pct) mode = MODE_DELETE;
      else if (roll < add_pct + del_pct + (100 - add_pct - del_pct) / 2) mode = MODE_QUERY;
      else mode = MODE_READ;
      if ($urandom_range(0, 9) == 0) begin
         value = $urandom();
         // Keep stray added values reachable by the sweep that empties the store.
         if (mode == MODE_ADD) pool.push_back(value);
      end else begin
         value = pool[$urandom_range(0, pool.size() - 1)];
      end
      pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 127)) : POS_W'($urandom_range(0, 15));
      send_request(mode, value, pos);
   endtask

   task automatic run_phase(input logic [CAPACITY_W-1:0] cap, input int pool_n, input int n,
                            input int add_pct, input int del_pct);
      settle();
      write_capacity(cap);
      if (pool_n > 0) build_pool(pool_n);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (n) random_request(add_pct, del_pct);
   endtask

   // Deletes every pool value, which leaves the store empty.
   task automatic sweep_pool();
      int start;
      start = $urandom_range(0, pool.size() - 1);
      for (int i = 0; i < pool.size(); i++)
         send_request(MODE_DELETE, pool[(start + i) % pool.size()],
                      POS_W'($urandom_range(0, 127)));
   endtask

   initial begin
      int cap;
      int pool_n;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset capacity.
      send_request(MODE_READ, 32'd0, 7'd0);
      send_request(MODE_READ, 32'd0, 7'd127);
      send_request(MODE_QUERY, 32'h8000_0000, 7'd0);
      send_request(MODE_DELETE, 32'h7FFF_FFFF, 7'd0);
      send_request(MODE_ADD, 32'h8000_0000, 7'd0);
      send_request(MODE_ADD, 32'h7FFF_FFFF, 7'd0);
      send_request(MODE_ADD, 32'h0000_0000, 7'd0);
      send_request(MODE_ADD, 32'hFFFF_FFFF, 7'd0);
      send_request(MODE_ADD, 32'h8000_0000, 7'd127);
      send_request(MODE_QUERY, 32'h7FFF_FFFF, 7'd0);
      send_request(MODE_QUERY, 32'h0000_0001, 7'd0);
      send_request(MODE_READ, 32'd0, 7'd0);
      send_request(MODE_READ, 32'hFFFF_FFFF, 7'd127);
      send_request(MODE_READ, 32'd0, 7'd1);
      send_request(MODE_DELETE, 32'h0000_0000, 7'd0);
      send_request(MODE_READ, 32'd0, 7'd2);
      send_request(MODE_DELETE, 32'h8000_0000, 7'd0);
      send_request(MODE_DELETE, 32'hFFFF_FFFF, 7'd0);
      send_request(MODE_READ, 32'd0, 7'd0);
      settle();
      write_capacity(8'd1);
      send_request(MODE_ADD, 32'd5, 7'd0);
      // Already present and full at once: the duplicate must win.
      send_request(MODE_ADD, 32'h7FFF_FFFF, 7'd0);
      settle();
      write_capacity(8'd0);
      send_request(MODE_ADD, 32'd6, 7'd0);
      send_request(MODE_DELETE, 32'h7FFF_FFFF, 7'd0);
      send_request(MODE_ADD, 32'd6, 7'd0);
      send_request(MODE_ADD, 32'd7, 7'd0);
      send_request(MODE_DELETE, 32'd6, 7'd0);

      // Fill to the full depth, then push past it and lower the capacity below the count.
      run_phase(8'd128, 170, 300, 85, 5);
      run_phase(8'd255, 0, 100, 50, 10);
      run_phase(8'd10, 0, 150, 30, 45);
      sweep_pool();

      repeat (9) begin
         if ($urandom_range(0, 4) == 0) cap = $urandom_range(0, 255);
         else cap = $urandom_range(1, 24);
         pool_n = ((cap > 40) ? 40 : cap) + $urandom_range(2, 8);
         run_phase(CAPACITY_W'(cap), pool_n, 70, 45, 25);
         sweep_pool();
      end

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("bounded_integer_set_store regression: pass");
      end else begin
         $display("bounded_integer_set_store regression: fail");
      end
      $finish;
   end

endmodule
